[rtl/rpblw_pkg.sv]
// Shared types and constants for the rectangle pixel block-linear writer.
`default_nettype none

package rpblw_pkg;

  localparam int unsigned COORD_W   = 11;
  localparam int unsigned ADDR_W    = 22;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned BUFFER_WIDTH_DFLT  = 1280;
  localparam int unsigned LINEAR_STRIDE_DFLT = 1280;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PIX_W-1:0]   pix_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_LEFT     = 3'd0,
    REG_AREA_TOP      = 3'd1,
    REG_AREA_RIGHT    = 3'd2,
    REG_AREA_BOTTOM   = 3'd3,
    REG_LINEAR_LAYOUT = 3'd4,
    REG_RENDER_ENABLE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } area_t;

  typedef struct packed {
    coord_t col;
    coord_t row;
    logic   done;
  } pos_t;

endpackage

`default_nettype wire

[rtl/rect_pixel_block_linear_writer.sv]
// Rectangle pixel writer: turns a row-ordered pixel stream into framebuffer writes.
//
// Usage:
//   Input beats (in_valid/in_stall) carry one pixel each; in_area_start marks the
//   first pixel of a rectangle and snaps the position to (area_left, area_top).
//   Output beats (out_valid/out_stall) carry the word address, the pixel and
//   out_area_done on the bottom-right pixel. With render_enable at 0 pixels are
//   consumed and the position advances, but no output beat is produced.
//   An accepted pixel is registered in the pixel stage, then in the output
//   register, and is shown on out_*. Throughput is one pixel per cycle while
//   out_stall is low; the position tracker and pixel stage feed that register.
//   When the receiver stalls with the output register and pixel stage full,
//   in_stall goes high in the same cycle; no beat is lost or repeated.
//   Reset clears the position to (0,0), all area registers and layout to 0,
//   render_enable to 1, and empties the pipeline.
//   Configuration is written through cfg_write_en/cfg_index/cfg_write_data; the
//   user must do so while no pixel is in flight, as the block does not enforce it.
`default_nettype none

module rect_pixel_block_linear_writer #(
  parameter int unsigned BUFFER_WIDTH  = rpblw_pkg::BUFFER_WIDTH_DFLT,
  parameter int unsigned LINEAR_STRIDE = rpblw_pkg::LINEAR_STRIDE_DFLT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_write_en,
  input  wire logic [rpblw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rpblw_pkg::COORD_W-1:0]    cfg_write_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [rpblw_pkg::PIX_W-1:0]      in_pixel_value,
  input  wire logic                             in_area_start,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [rpblw_pkg::ADDR_W-1:0]          out_word_address,
  output logic [rpblw_pkg::PIX_W-1:0]           out_write_data,
  output logic                                  out_area_done
);
  import rpblw_pkg::*;

  area_t area_r;
  logic  linear_r;
  logic  render_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r   <= '0;
      linear_r <= 1'b0;
      render_r <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_AREA_LEFT:     area_r.left   <= cfg_write_data;
        REG_AREA_TOP:      area_r.top    <= cfg_write_data;
        REG_AREA_RIGHT:    area_r.right  <= cfg_write_data;
        REG_AREA_BOTTOM:   area_r.bottom <= cfg_write_data;
        REG_LINEAR_LAYOUT: linear_r      <= cfg_write_data[0];
        REG_RENDER_ENABLE: render_r      <= cfg_write_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic out_load;
  logic s1_load;
  logic accept;
  logic s1_valid_r;

  assign out_load = !out_valid || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;
  assign accept   = in_valid && s1_load;

  pos_t cur_pos;

  rpblw_pos u_pos (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .start (in_area_start),
    .area  (area_r),
    .cur   (cur_pos)
  );

  // pixel stage
  pos_t s1_pos_r;
  pix_t s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= accept && render_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r <= cur_pos;
      s1_pix_r <= in_pixel_value;
    end
  end

  addr_t addr;

  rpblw_addr #(
    .BUFFER_WIDTH (BUFFER_WIDTH),
    .LINEAR_STRIDE(LINEAR_STRIDE)
  ) u_addr (
    .pos   (s1_pos_r),
    .linear(linear_r),
    .addr  (addr)
  );

  // output register
  logic  out_valid_r;
  addr_t out_addr_r;
  pix_t  out_data_r;
  logic  out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid_r) begin
      out_addr_r <= addr;
      out_data_r <= s1_pix_r;
      out_done_r <= s1_pos_r.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_address = out_addr_r;
  assign out_write_data   = out_data_r;
  assign out_area_done    = out_done_r;

endmodule

`default_nettype wire

[rtl/rpblw_pos.sv]
// Column/row tracker: places each accepted pixel and steps through the rectangle.
`default_nettype none

module rpblw_pos (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            start,
  input  wire rpblw_pkg::area_t area,
  output rpblw_pkg::pos_t      cur
);
  import rpblw_pkg::*;

  coord_t col_r, col_nxt;
  coord_t row_r, row_nxt;
  coord_t x, y;
  logic   done;

  always_comb begin
    x    = start ? area.left : col_r;
    y    = start ? area.top  : row_r;
    done = (x == area.right) && (y == area.bottom);
    if (done) begin
      col_nxt = area.left;
      row_nxt = area.top;
    end else if (x >= area.right) begin
      col_nxt = area.left;
      row_nxt = y + coord_t'(1);
    end else begin
      col_nxt = x + coord_t'(1);
      row_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign cur = '{col: x, row: y, done: done};

endmodule

`default_nettype wire

[rtl/rpblw_addr.sv]
// Framebuffer address generator: 16x16 tile swizzle or linear row-stride addressing.
`default_nettype none

module rpblw_addr #(
  parameter int unsigned BUFFER_WIDTH  = rpblw_pkg::BUFFER_WIDTH_DFLT,
  parameter int unsigned LINEAR_STRIDE = rpblw_pkg::LINEAR_STRIDE_DFLT
) (
  input  wire rpblw_pkg::pos_t  pos,
  input  wire logic             linear,
  output rpblw_pkg::addr_t      addr
);
  import rpblw_pkg::*;

  // tiles per 128-row band
  localparam int unsigned TILE_ROW = (BUFFER_WIDTH / 16) * 8;

  logic [31:0] tile;
  logic [31:0] lin;
  logic [7:0]  sub;
  addr_t       swz;

  always_comb begin
    tile = 32'({pos.col[10:4], pos.row[6:4]}) + 32'(pos.row[10:7]) * 32'(TILE_ROW);
    sub  = {pos.row[3], pos.col[3], pos.row[2:1], pos.col[2], pos.row[0], pos.col[1:0]};
    swz  = {tile[ADDR_W-9:0], sub};
    lin  = 32'(pos.row) * 32'(LINEAR_STRIDE) + 32'(pos.col);
    addr = linear ? lin[ADDR_W-1:0] : swz;
  end

endmodule

`default_nettype wire

[rtl/rpblw_chk.sv]
// Port-level checker for the rectangle pixel writer, bound to the top level.
`default_nettype none

module rpblw_chk (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [rpblw_pkg::ADDR_W-1:0]     out_word_address,
  input wire logic [rpblw_pkg::PIX_W-1:0]      out_write_data,
  input wire logic                             out_area_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word_address) && $stable(out_write_data)
      && $stable(out_area_done))
    else $error("stalled output payload changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output side is free");

endmodule

bind rect_pixel_block_linear_writer rpblw_chk u_rpblw_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_word_address(out_word_address),
  .out_write_data  (out_write_data),
  .out_area_done   (out_area_done)
);

`default_nettype wire
